@@ design/crm_pkg.sv @@
// crm_pkg: shared constants, codes and types of the can multiframe reassembler
// used by crm_seg_ram, crm_session and can_multiframe_reassembler
`default_nettype none

package crm_pkg;

   localparam int SegmentBytes = 7;
   localparam int SegmentCount = 16;
   localparam int SlotW        = $clog2(SegmentCount);
   localparam int WordW        = 56;
   localparam int AddrW        = 7;
   // reciprocal of the segment size, scaled by 2**RecipShift, rounded up
   localparam int RecipShift   = 10;
   localparam int RecipMul     = ((1 << RecipShift) + SegmentBytes - 1) / SegmentBytes;
   localparam int RecipW       = 8;
   localparam int ProdW        = AddrW + RecipW;

   typedef enum logic [1:0] {
      CMD_RECEIVE = 2'd0,
      CMD_READ    = 2'd1,
      CMD_CLEAR   = 2'd2,
      CMD_NOP     = 2'd3
   } command_type;

   typedef enum logic [3:0] {
      OUT_IGNORED   = 4'd0,
      OUT_FIRST     = 4'd1,
      OUT_NEXT      = 4'd2,
      OUT_COMPLETE  = 4'd3,
      OUT_SEQ_ERROR = 4'd4,
      OUT_ERR_RESET = 4'd5,
      OUT_OVERRUN   = 4'd6,
      OUT_READ      = 4'd7,
      OUT_CLEARED   = 4'd8
   } outcome_type;

   // item waiting for its state update
   typedef struct packed {
      command_type      command;
      logic [7:0]       header_byte;
      logic [WordW-1:0] payload_bytes;
      logic [3:0]       frame_length;
      logic [4:0]       slot;
      logic [2:0]       pos;
   } item_type;

   typedef struct packed {
      logic             en;
      logic [SlotW-1:0] addr;
      logic [WordW-1:0] data;
   } wr_type;

   typedef struct packed {
      outcome_type outcome;
      logic        message_done;
      logic [3:0]  last_segment;
      logic [3:0]  segment_index;
      logic [7:0]  payload_length;
      logic [7:0]  error_count;
      logic [7:0]  read_data;
   } result_type;

endpackage

`default_nettype wire

@@ design/crm_seg_ram.sv @@
// crm_seg_ram: segment store, one synchronous read port and one write port
// per-entry valid bits make never-written or cleared entries read as zero; uses crm_pkg
`default_nettype none

module crm_seg_ram (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         rd_en,
   input  wire logic [crm_pkg::SlotW-1:0]    rd_addr,
   input  wire crm_pkg::wr_type              wr,
   input  wire logic                         clear,
   output logic      [crm_pkg::WordW-1:0]    rd_data
);
   import crm_pkg::*;

   logic [WordW-1:0]        mem [SegmentCount];
   logic [SegmentCount-1:0] valid_ff;
   logic [WordW-1:0]        rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (clear) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en && !clear) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= valid_ff[rd_addr] ? mem[rd_addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ design/crm_session.sv @@
// crm_session: session registers and the per-item update of the reassembler
// merges the frame into the old slot word and issues the write back; uses crm_pkg
`default_nettype none

module crm_session (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      fire,
   input  wire crm_pkg::item_type         item,
   input  wire logic [crm_pkg::WordW-1:0] old_word,
   output crm_pkg::result_type            result,
   output crm_pkg::wr_type                wr,
   output logic                           clear
);
   import crm_pkg::*;

   logic [3:0] last_ff, last_in;
   logic [3:0] index_ff, index_in;
   logic       done_ff, done_in;
   logic [7:0] total_ff, total_in;
   logic [7:0] errors_ff, errors_in;

   logic [3:0]       idx;
   logic [3:0]       len_cap;
   logic [3:0]       n_raw;
   logic [3:0]       n;
   logic [WordW-1:0] mask;
   logic [8:0]       total_sum;
   logic             store;
   logic             slot_ok;
   outcome_type      outcome;
   logic [7:0]       rd;

   always_comb begin
      idx     = item.header_byte[3:0];
      len_cap = (item.frame_length > 4'd8) ? 4'd8 : item.frame_length;
      n_raw   = len_cap - 4'd1;
      n       = (n_raw > 4'(SegmentBytes)) ? 4'(SegmentBytes) : n_raw;
      for (int i = 0; i < WordW / 8; i++) begin
         mask[i*8 +: 8] = (4'(i) < n) ? 8'hff : 8'h00;
      end
      total_sum = {1'b0, total_ff} + {5'b0, n};
      slot_ok   = item.slot < 5'(SegmentCount);
   end

   always_comb begin
      last_in   = last_ff;
      index_in  = index_ff;
      done_in   = done_ff;
      total_in  = total_ff;
      errors_in = errors_ff;
      outcome   = OUT_IGNORED;
      rd        = 8'd0;
      store     = 1'b0;
      clear     = 1'b0;
      wr.en     = 1'b0;
      wr.addr   = SlotW'(item.slot);
      wr.data   = (old_word & ~mask) | (item.payload_bytes & mask);
      unique case (item.command)
         CMD_RECEIVE: begin
            if (item.header_byte != 8'd0 && !done_ff && item.frame_length != 4'd0) begin
               if (idx == 4'd0) begin
                  last_in  = item.header_byte[7:4];
                  index_in = 4'd0;
                  store    = 1'b1;
                  outcome  = OUT_FIRST;
               end else if (idx - 4'd1 == index_ff) begin
                  index_in = idx;
                  store    = 1'b1;
                  if (idx == last_ff) begin
                     done_in = 1'b1;
                     outcome = OUT_COMPLETE;
                  end else begin
                     outcome = OUT_NEXT;
                  end
               end else begin
                  errors_in = (errors_ff == 8'hff) ? errors_ff : errors_ff + 8'd1;
                  if (errors_in > 8'd3) begin
                     clear   = 1'b1;
                     outcome = OUT_ERR_RESET;
                  end else begin
                     outcome = OUT_SEQ_ERROR;
                  end
               end
               if (store && n != 4'd0) begin
                  total_in = total_sum[8] ? 8'hff : total_sum[7:0];
                  wr.en    = slot_ok;
               end
               if (!clear && index_in > last_in) begin
                  clear   = 1'b1;
                  outcome = OUT_OVERRUN;
               end
            end
         end
         CMD_READ: begin
            outcome = OUT_READ;
            if (slot_ok) begin
               rd = old_word[item.pos*8 +: 8];
            end
         end
         CMD_CLEAR: begin
            clear   = 1'b1;
            outcome = OUT_CLEARED;
         end
         default: begin
            outcome = OUT_IGNORED;
         end
      endcase
      if (clear) begin
         last_in  = 4'd0;
         index_in = 4'd0;
         done_in  = 1'b0;
         total_in = 8'd0;
         wr.en    = 1'b0;
      end
      if (!fire) begin
         wr.en = 1'b0;
         clear = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff   <= '0;
         index_ff  <= '0;
         done_ff   <= 1'b0;
         total_ff  <= '0;
         errors_ff <= '0;
      end else if (fire) begin
         last_ff   <= last_in;
         index_ff  <= index_in;
         done_ff   <= done_in;
         total_ff  <= total_in;
         errors_ff <= errors_in;
      end
   end

   always_comb begin
      result.outcome        = outcome;
      result.message_done   = done_in;
      result.last_segment   = last_in;
      result.segment_index  = index_in;
      result.payload_length = total_in;
      result.error_count    = errors_in;
      result.read_data      = rd;
   end

endmodule

`default_nettype wire

@@ design/can_multiframe_reassembler.sv @@
// can_multiframe_reassembler: top level, input stage with forwarding and output register
// instantiates crm_seg_ram and crm_session; uses crm_pkg
`default_nettype none

// Rebuilds a multi-frame CAN message in a 16-slot segment store. Each item is a
// receive, read, clear or no-op command and yields exactly one result item. An accepted item
// reads its slot from the store in the cycle it is taken, then updates the session
// registers and writes the slot back when it leaves the update stage, which waits while
// the result register holds an untaken result; as the store read of one item overlaps the
// write back of the one before (with forwarding of that write), a new item is taken every
// cycle when the result side keeps up. Read commands address the buffer by byte (slot = address / 7). The
// error count survives session resets and is cleared only by reset.

module can_multiframe_reassembler (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [79:0] req_tdata,  // header_byte, payload_bytes, frame_length, read_address
   input  wire logic [1:0]  req_tuser,  // command
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [39:0] rsp_tdata,  // message_done, last_segment, segment_index,
                                        // payload_length, error_count, read_data
   output logic      [3:0]  rsp_tuser   // outcome
);
   import crm_pkg::*;

   logic [7:0]       in_header;
   logic [WordW-1:0] in_payload;
   logic [3:0]       in_length;
   logic [AddrW-1:0] in_address;
   logic [ProdW-1:0] addr_prod;
   logic [4:0]       rd_slot;
   logic [AddrW-1:0] slot_base;
   logic [2:0]       rd_pos;
   logic [SlotW-1:0] ram_addr;
   logic             accept;
   logic             fire;

   item_type         item_ff, item_in;
   logic             s1_valid_ff;
   logic             fwd_hit_ff;
   logic             fwd_clr_ff;
   logic [WordW-1:0] fwd_data_ff;
   logic [WordW-1:0] ram_data;
   logic [WordW-1:0] old_word;

   result_type       result;
   result_type       rsp_ff;
   logic             rsp_valid_ff;
   wr_type           wr;
   logic             clear;

   assign in_header  = req_tdata[7:0];
   assign in_payload = req_tdata[63:8];
   assign in_length  = req_tdata[67:64];
   assign in_address = req_tdata[74:68];

   always_comb begin
      addr_prod = ProdW'(in_address) * ProdW'(RecipMul);
      rd_slot   = 5'(addr_prod >> RecipShift);
      slot_base = AddrW'(rd_slot) * AddrW'(SegmentBytes);
      rd_pos    = 3'(in_address - slot_base);
      item_in.command       = command_type'(req_tuser);
      item_in.header_byte   = in_header;
      item_in.payload_bytes = in_payload;
      item_in.frame_length  = in_length;
      item_in.slot          = (command_type'(req_tuser) == CMD_READ) ? rd_slot
                                                                      : {1'b0, in_header[3:0]};
      item_in.pos           = rd_pos;
      ram_addr              = SlotW'(item_in.slot);
   end

   assign fire       = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || fire;
   assign accept     = req_tvalid && req_tready;

   crm_seg_ram u_seg_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (ram_addr),
      .wr      (wr),
      .clear   (clear),
      .rd_data (ram_data)
   );

   always_comb begin
      if (fwd_clr_ff) begin
         old_word = '0;
      end else if (fwd_hit_ff) begin
         old_word = fwd_data_ff;
      end else begin
         old_word = ram_data;
      end
   end

   crm_session u_session (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .item     (item_ff),
      .old_word (old_word),
      .result   (result),
      .wr       (wr),
      .clear    (clear)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (fire) begin
            s1_valid_ff <= 1'b0;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff     <= item_in;
         fwd_clr_ff  <= clear;
         fwd_hit_ff  <= wr.en && (wr.addr == ram_addr);
         fwd_data_ff <= wr.data;
      end
      if (fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.outcome;
   assign rsp_tdata  = {7'b0, rsp_ff.read_data, rsp_ff.error_count, rsp_ff.payload_length,
                        rsp_ff.segment_index, rsp_ff.last_segment, rsp_ff.message_done};

   a_complete_sets_done : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_ff.outcome == OUT_COMPLETE |-> rsp_ff.message_done)
      else $error("complete outcome without message_done");

   a_reset_clears_session : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_ff.outcome == OUT_ERR_RESET || rsp_ff.outcome == OUT_OVERRUN ||
                     rsp_ff.outcome == OUT_CLEARED)
      |-> !rsp_ff.message_done && rsp_ff.payload_length == 8'd0 &&
          rsp_ff.segment_index == 4'd0)
      else $error("session reset left state behind");

   a_write_only_on_fire : assert property (@(posedge clock) disable iff (reset)
      (wr.en || clear) |-> fire)
      else $error("segment store touched without an item in flight");

   a_ready_when_empty : assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_tready)
      else $error("input stalled with empty update stage");

endmodule

`default_nettype wire

@@ bench/can_multiframe_reassembler_tb.sv @@
// can_multiframe_reassembler_tb: self-checking bench for the can multiframe reassembler
// drives frames, reads and clears with random gaps, checks every status item against
// an in-bench session model or a typed result; depends on crm_pkg and the design only
`timescale 1ns / 1ps
`default_nettype none

module can_multiframe_reassembler_tb;
   import crm_pkg::*;

   typedef struct {
      command_type cmd;
      logic [7:0]  hdr;
      logic [55:0] pl;
      logic [3:0]  dlc;
      logic [6:0]  addr;
      bit          typed;
      result_type  want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [79:0] req_tdata;  // header_byte, payload_bytes, frame_length, read_address
   logic [1:0]  req_tuser;  // command
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;  // message_done, last_segment, segment_index,
                            // payload_length, error_count, read_data
   logic [3:0]  rsp_tuser;  // outcome

   // session model
   logic [55:0] seg_mem [16];
   logic [3:0]  last_seg;
   logic [4:0]  seg_idx;
   logic        msg_done;
   logic [7:0]  byte_count;
   logic [7:0]  err_tally;

   result_type   awaited_status[$];
   stim_row_type directed_rows[$];
   int           failures = 0;
   int           items_sent = 0;
   int           live_items = 0;
   int           status_checked = 0;
   int           outcome_seen[9];
   bit           sender_steady = 1'b0;
   bit           receiver_steady = 1'b0;

   can_multiframe_reassembler i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   initial begin
      #2000000;
      $display("== FAIL ==");
      $finish;
   end

   function automatic void clear_session();
      foreach (seg_mem[i]) seg_mem[i] = '0;
      last_seg   = '0;
      seg_idx    = '0;
      msg_done   = 1'b0;
      byte_count = '0;
   endfunction

   function automatic void store_bytes(int slot, logic [55:0] pl, int n);
      if (n == 0) return;
      byte_count = (int'(byte_count) + n > 255) ? 8'd255 : byte_count + 8'(n);
      if (slot >= 16) return;
      for (int b = 0; b < n; b++) seg_mem[slot][b*8 +: 8] = pl[b*8 +: 8];
   endfunction

   function automatic result_type reassemble_step(command_type cmd, logic [7:0] hdr,
                                                  logic [55:0] pl, logic [3:0] dlc,
                                                  logic [6:0] addr);
      int         idx;
      int         nbytes;
      int         slot;
      int         pos;
      result_type r;
      r = '0;
      r.outcome = OUT_IGNORED;
      case (cmd)
         CMD_RECEIVE: begin
            if (hdr != 0 && !msg_done && dlc != 0) begin
               idx = hdr[3:0];
               nbytes = ((dlc > 8) ? 8 : int'(dlc)) - 1;
               if (idx == 0) begin
                  last_seg = hdr[7:4];
                  seg_idx = '0;
                  store_bytes(0, pl, nbytes);
                  r.outcome = OUT_FIRST;
               end else if (idx - 1 == int'(seg_idx)) begin
                  seg_idx = seg_idx + 5'd1;
                  store_bytes(seg_idx, pl, nbytes);
                  if (seg_idx == {1'b0, last_seg}) begin
                     msg_done = 1'b1;
                     r.outcome = OUT_COMPLETE;
                  end else begin
                     r.outcome = OUT_NEXT;
                  end
               end else begin
                  if (err_tally != 8'd255) err_tally = err_tally + 8'd1;
                  if (err_tally > 3) begin
                     clear_session();
                     r.outcome = OUT_ERR_RESET;
                  end else begin
                     r.outcome = OUT_SEQ_ERROR;
                  end
               end
               if (seg_idx > {1'b0, last_seg}) begin
                  clear_session();
                  r.outcome = OUT_OVERRUN;
               end
            end
         end
         CMD_READ: begin
            slot = addr / SegmentBytes;
            pos = addr % SegmentBytes;
            if (slot < 16) r.read_data = seg_mem[slot][pos*8 +: 8];
            r.outcome = OUT_READ;
         end
         CMD_CLEAR: begin
            clear_session();
            r.outcome = OUT_CLEARED;
         end
         default: r.outcome = OUT_IGNORED;
      endcase
      r.message_done   = msg_done;
      r.last_segment   = last_seg;
      r.segment_index  = seg_idx[3:0];
      r.payload_length = byte_count;
      r.error_count    = err_tally;
      return r;
   endfunction

   function automatic result_type typed_result(outcome_type oc, int last, int idx, int len,
                                               int err);
      result_type r;
      r = '0;
      r.outcome = oc;
      r.last_segment = 4'(last);
      r.segment_index = 4'(idx);
      r.payload_length = 8'(len);
      r.error_count = 8'(err);
      return r;
   endfunction

   function automatic void add_row(command_type cmd, logic [7:0] hdr, logic [55:0] pl,
                                   logic [3:0] dlc, logic [6:0] addr, bit typed,
                                   result_type want);
      stim_row_type row;
      row.cmd = cmd;
      row.hdr = hdr;
      row.pl = pl;
      row.dlc = dlc;
      row.addr = addr;
      row.typed = typed;
      row.want = want;
      directed_rows.push_back(row);
   endfunction

   function automatic logic [55:0] rand_payload();
      logic [63:0] v;
      v = {$urandom, $urandom};
      return v[55:0];
   endfunction

   function automatic logic [3:0] rand_dlc();
      if ($urandom_range(0, 2) != 0) return 4'd8;
      return 4'($urandom_range(1, 15));
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endfunction

   task automatic issue_item(command_type cmd, logic [7:0] hdr, logic [55:0] pl,
                             logic [3:0] dlc, logic [6:0] addr, bit typed = 1'b0,
                             result_type want = '0);
      int         gap;
      result_type got;
      if ($urandom_range(0, 31) == 0) sender_steady = ~sender_steady;
      gap = sender_steady ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {5'b0, addr, dlc, pl, hdr};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      got = reassemble_step(cmd, hdr, pl, dlc, addr);
      awaited_status.push_back(typed ? want : got);
      items_sent++;
      if (got.outcome != OUT_IGNORED) live_items++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (awaited_status.size() != 0) @(negedge clock);
   endtask

   task automatic send_message();
      int          span;
      int          bad;
      int          reads;
      logic [3:0]  hi;
      span = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 15) : $urandom_range(1, 4);
      issue_item(CMD_RECEIVE, {4'(span), 4'd0}, rand_payload(), rand_dlc(), '0);
      for (int i = 1; i <= span; i++) begin
         hi = 4'($urandom_range(0, 15));
         if ($urandom_range(0, 19) == 0)
            issue_item(CMD_RECEIVE, {hi, 4'(i)}, rand_payload(), 4'd0, '0);
         if ($urandom_range(0, 24) == 0) begin
            do bad = $urandom_range(1, 15); while (bad == i);
            issue_item(CMD_RECEIVE, {hi, 4'(bad)}, rand_payload(), rand_dlc(), '0);
            break;
         end
         issue_item(CMD_RECEIVE, {hi, 4'(i)}, rand_payload(), rand_dlc(), '0);
      end
      reads = $urandom_range(0, 3);
      repeat (reads)
         issue_item(CMD_READ, 8'($urandom), rand_payload(), 4'($urandom_range(0, 15)),
                    ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                                : 7'($urandom_range(0, 7 * span + 6)));
      if ($urandom_range(0, 3) != 0)
         issue_item(CMD_CLEAR, 8'($urandom), rand_payload(), 4'($urandom), 7'($urandom));
   endtask

   task automatic run_traffic(int target);
      int goal;
      int burst;
      goal = live_items + target;
      while (live_items < goal) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: send_message();
            5: begin
               burst = $urandom_range(2, 8);
               repeat (burst)
                  issue_item(CMD_RECEIVE, {4'($urandom_range(1, 15)), 4'd0}, rand_payload(),
                             4'd8, '0);
            end
            6: begin
               issue_item(CMD_CLEAR, 8'($urandom), rand_payload(), 4'($urandom), 7'($urandom));
               issue_item(CMD_RECEIVE, {4'($urandom), 4'd1}, rand_payload(), rand_dlc(), '0);
            end
            7: issue_item(CMD_READ, 8'($urandom), rand_payload(), 4'($urandom),
                          7'($urandom_range(0, 127)));
            8: issue_item(($urandom_range(0, 1) == 0) ? CMD_CLEAR : CMD_NOP, 8'($urandom),
                          rand_payload(), 4'($urandom), 7'($urandom));
            default: issue_item(command_type'($urandom_range(0, 3)), 8'($urandom),
                                rand_payload(), 4'($urandom_range(0, 15)),
                                7'($urandom_range(0, 127)));
         endcase
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = CMD_NOP;
      foreach (outcome_seen[i]) outcome_seen[i] = 0;
      clear_session();
      err_tally = '0;

      add_row(CMD_READ,    8'h00, '0,             4'd0,  7'd0,   1,
              typed_result(OUT_READ, 0, 0, 0, 0));
      add_row(CMD_READ,    8'h00, '0,             4'd0,  7'd127, 1,
              typed_result(OUT_READ, 0, 0, 0, 0));
      add_row(CMD_NOP,     8'hff, '1,             4'hf,  7'h7f,  1,
              typed_result(OUT_IGNORED, 0, 0, 0, 0));
      add_row(CMD_RECEIVE, 8'h00, '1,             4'd8,  7'd0,   1,
              typed_result(OUT_IGNORED, 0, 0, 0, 0));
      add_row(CMD_RECEIVE, 8'h10, '1,             4'd0,  7'd0,   1,
              typed_result(OUT_IGNORED, 0, 0, 0, 0));
      add_row(CMD_RECEIVE, 8'h01, '1,             4'd8,  7'd0,   1,
              typed_result(OUT_OVERRUN, 0, 0, 0, 0));
      add_row(CMD_RECEIVE, 8'h30, '1,             4'd15, 7'd0,   1,
              typed_result(OUT_FIRST, 3, 0, 7, 0));
      add_row(CMD_RECEIVE, 8'h31, rand_payload(), 4'd1,  7'd0,   1,
              typed_result(OUT_NEXT, 3, 1, 7, 0));
      add_row(CMD_RECEIVE, 8'h32, rand_payload(), 4'd4,  7'd0,   0, '0);
      add_row(CMD_RECEIVE, 8'h35, rand_payload(), 4'd8,  7'd0,   1,
              typed_result(OUT_SEQ_ERROR, 3, 2, 10, 1));
      add_row(CMD_RECEIVE, 8'h3f, rand_payload(), 4'd8,  7'd0,   1,
              typed_result(OUT_SEQ_ERROR, 3, 2, 10, 2));
      add_row(CMD_RECEIVE, 8'h3e, rand_payload(), 4'd8,  7'd0,   1,
              typed_result(OUT_SEQ_ERROR, 3, 2, 10, 3));
      add_row(CMD_RECEIVE, 8'h3d, rand_payload(), 4'd8,  7'd0,   1,
              typed_result(OUT_ERR_RESET, 0, 0, 0, 4));
      add_row(CMD_RECEIVE, 8'h20, rand_payload(), 4'd8,  7'd0,   0, '0);
      add_row(CMD_READ,    8'h00, '0,             4'd0,  7'd3,   0, '0);
      add_row(CMD_RECEIVE, 8'h21, rand_payload(), 4'd8,  7'd0,   0, '0);
      add_row(CMD_RECEIVE, 8'h22, rand_payload(), 4'd6,  7'd0,   0, '0);
      add_row(CMD_RECEIVE, 8'h10, rand_payload(), 4'd8,  7'd0,   0, '0);
      add_row(CMD_READ,    8'h00, '0,             4'd0,  7'd111, 0, '0);
      add_row(CMD_READ,    8'h00, '0,             4'd0,  7'd14,  0, '0);
      add_row(CMD_CLEAR,   8'h00, '0,             4'd0,  7'd0,   1,
              typed_result(OUT_CLEARED, 0, 0, 0, 4));
      add_row(CMD_RECEIVE, 8'hf0, '1,             4'd8,  7'd0,   0, '0);
      add_row(CMD_RECEIVE, 8'hf1, '0,             4'd8,  7'd0,   0, '0);
      add_row(CMD_RECEIVE, 8'hf0, '0,             4'd3,  7'd0,   0, '0);
      add_row(CMD_READ,    8'h00, '0,             4'd0,  7'd5,   0, '0);

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         issue_item(directed_rows[i].cmd, directed_rows[i].hdr, directed_rows[i].pl,
                    directed_rows[i].dlc, directed_rows[i].addr, directed_rows[i].typed,
                    directed_rows[i].want);
      wait_drained();

      run_traffic(220);
      wait_drained();

      // out-of-sequence storm drives the error count into saturation
      issue_item(CMD_CLEAR, 8'h00, '0, 4'd0, 7'd0);
      repeat (260)
         issue_item(CMD_RECEIVE, {4'($urandom), 4'($urandom_range(2, 15))}, rand_payload(),
                    4'($urandom_range(1, 15)), 7'($urandom));
      run_traffic(60);
      req_tvalid <= 1'b0;

      for (int guard = 0; guard < 100000 && awaited_status.size() != 0; guard++)
         @(negedge clock);
      repeat (10) @(negedge clock);
      if (awaited_status.size() != 0) begin
         $error("%0d status items never arrived", awaited_status.size());
         failures++;
      end

      $display("sent %0d items (%0d not ignored), checked %0d status items",
               items_sent, live_items, status_checked);
      $display("outcomes ignored..cleared: %0d %0d %0d %0d %0d %0d %0d %0d %0d",
               outcome_seen[0], outcome_seen[1], outcome_seen[2], outcome_seen[3],
               outcome_seen[4], outcome_seen[5], outcome_seen[6], outcome_seen[7],
               outcome_seen[8]);
      if (failures == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      int stall;
      rsp_tready = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         if ($urandom_range(0, 31) == 0) receiver_steady = ~receiver_steady;
         stall = receiver_steady ? 0 : $urandom_range(0, 11);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (rsp_tuser < 9) outcome_seen[rsp_tuser]++;
         if (awaited_status.size() == 0) begin
            $error("status item with nothing awaited: outcome %0d", rsp_tuser);
            failures++;
         end else begin
            want = awaited_status.pop_front();
            status_checked++;
            check_field("outcome",        want.outcome,        rsp_tuser);
            check_field("message_done",   want.message_done,   rsp_tdata[0]);
            check_field("last_segment",   want.last_segment,   rsp_tdata[4:1]);
            check_field("segment_index",  want.segment_index,  rsp_tdata[8:5]);
            check_field("payload_length", want.payload_length, rsp_tdata[16:9]);
            check_field("error_count",    want.error_count,    rsp_tdata[24:17]);
            check_field("read_data",      want.read_data,      rsp_tdata[32:25]);
         end
      end
   end

endmodule

`default_nettype wire
